/* rtl/qft_pkg.sv */
// Package for the quaternion frame transform unit.
// Holds widths, register indexes, transaction types and rounding helpers.
// No dependencies.
package qft_pkg;

    localparam int QW      = 16;
    localparam int VW      = 32;
    localparam int CW      = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_SH  = 2;

    localparam int PAW     = CW + VW;
    localparam int RVW     = 35;
    localparam int PFR     = 14;

    localparam int N2W     = 2 * QW + 1;
    localparam int SQSH    = 30;
    localparam int SQW     = N2W + SQSH;
    localparam int SQSTEPS = (SQW + 1) / 2;
    localparam int SW      = 32;

    localparam int UF      = 24;
    localparam int NUMSH   = 39;
    localparam int NUMW    = 56;
    localparam int QUOW    = 25;
    localparam int UW      = QUOW + 1;

    localparam int PRW     = UW + RVW;
    localparam int CRW     = PRW + 1;
    localparam int TW      = 40;
    localparam int TLW     = 20;
    localparam int THW     = TW - TLW;
    localparam int PHW     = UW + THW;
    localparam int PLW     = UW + TLW + 1;
    localparam int ACW     = 68;
    localparam int OW      = ACW - UF;
    localparam int PBW     = OW + 1;
    localparam int POW     = CW + PBW;
    localparam int PSW     = POW + 1;
    localparam int FW      = PSW - PFR;

    typedef enum logic {
        REG_PITCH_COS = 1'b0,
        REG_PITCH_SIN = 1'b1
    } t_reg_idx;

    localparam logic signed [CW-1:0] PITCH_COS_RST = 16'sd16384;
    localparam logic signed [CW-1:0] PITCH_SIN_RST = 16'sd0;

    typedef struct packed {
        logic                 req_type;
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] out_x;
        logic signed [VW-1:0] out_y;
        logic signed [VW-1:0] out_z;
        logic                 saturated;
        logic                 identity_used;
    } t_out_item;

    typedef struct packed {
        logic                     req;
        logic                     zero;
        logic [3:0][QW-1:0]       q;
        logic [2:0][RVW-1:0]      rv;
    } t_carry;

    typedef struct packed {
        t_carry         c;
        logic [SQW-1:0] n;
        logic [SQW-1:0] res;
    } t_sqrt_st;

    typedef struct packed {
        logic                   req;
        logic                   zero;
        logic [3:0]             neg;
        logic [2:0][RVW-1:0]    rv;
        logic [SW-1:0]          s;
        logic [3:0][NUMW-1:0]   rem;
        logic [3:0][QUOW-1:0]   quo;
    } t_div_st;

    function automatic logic signed [RVW-1:0] rnd_pin(input logic signed [PAW:0] v);
        logic signed [PAW:0] h;
        logic signed [PAW:0] t;
        h = v[PAW] ? $signed((PAW+1)'((1 << (PFR - 1)) - 1))
                   : $signed((PAW+1)'(1 << (PFR - 1)));
        t = v + h;
        return RVW'(t >>> PFR);
    endfunction

    function automatic logic signed [TW-1:0] rnd_t(input logic signed [CRW-1:0] v);
        logic signed [CRW-1:0] h;
        logic signed [CRW-1:0] t;
        h = v[CRW-1] ? $signed(CRW'((1 << (UF - 2)) - 1))
                     : $signed(CRW'(1 << (UF - 2)));
        t = v + h;
        return TW'(t >>> (UF - 1));
    endfunction

    function automatic logic signed [OW-1:0] rnd_acc(input logic signed [ACW-1:0] v);
        logic signed [ACW-1:0] h;
        logic signed [ACW-1:0] t;
        h = v[ACW-1] ? $signed(ACW'((1 << (UF - 1)) - 1))
                     : $signed(ACW'(1 << (UF - 1)));
        t = v + h;
        return OW'(t >>> UF);
    endfunction

    function automatic logic signed [FW-1:0] rnd_pout(input logic signed [PSW-1:0] v);
        logic signed [PSW-1:0] h;
        logic signed [PSW-1:0] t;
        h = v[PSW-1] ? $signed(PSW'((1 << (PFR - 1)) - 1))
                     : $signed(PSW'(1 << (PFR - 1)));
        t = v + h;
        return FW'(t >>> PFR);
    endfunction

endpackage

/* rtl/qft_if.sv */
// Stream interfaces for the quaternion frame transform unit.
// Depends on qft_pkg for the transaction types.
interface qft_in_if import qft_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface qft_out_if import qft_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/quaternion_frame_transform_unit.sv */
// Quaternion frame transform unit: rotates a Q16.16 vector between camera map and body frames.
// Depends on qft_pkg and the stream interfaces in qft_if.
// The unit takes one transaction per clock and returns one result transaction for each, in
// order. The pipeline includes the 32-stage square root of the quaternion norm and the
// 25-stage divider that normalizes the components. The whole pipeline advances together
// and holds while a result waits in the output register unclaimed.
module quaternion_frame_transform_unit import qft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qft_in_if.sink            i_in,
    qft_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic signed [CW-1:0] r_pcos, r_psin;
    logic                 w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcos <= PITCH_COS_RST;
            r_psin <= PITCH_SIN_RST;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[REG_SH]))
                REG_PITCH_COS: r_pcos <= pwdata[CW-1:0];
                REG_PITCH_SIN: r_psin <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[REG_SH]))
            REG_PITCH_COS: prdata = {{(APB_DW-CW){r_pcos[CW-1]}}, r_pcos};
            REG_PITCH_SIN: prdata = {{(APB_DW-CW){r_psin[CW-1]}}, r_psin};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic      r_out_v;
    t_out_item r_out;

    assign w_en        = !r_out_v || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    // Input register.
    logic     r_v0;
    t_in_item r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= i_in.data;
        end
    end

    // Squares of the quaternion and pitch products for the body-to-map direction.
    logic signed [QW-1:0]   w_q0 [4];
    logic signed [2*QW-1:0] w_q2 [4];
    logic signed [PAW-1:0]  n_pa [4];
    logic [N2W-1:0]         r_sq1 [4];
    logic signed [PAW-1:0]  r_pa1 [4];
    t_in_item               r_s1;
    logic                   r_v1;

    assign w_q0[0] = r_s0.quat_w;
    assign w_q0[1] = r_s0.quat_x;
    assign w_q0[2] = r_s0.quat_y;
    assign w_q0[3] = r_s0.quat_z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_q2[i] = w_q0[i] * w_q0[i];
        end
        n_pa[0] = r_pcos * $signed(r_s0.vec_x);
        n_pa[1] = r_psin * $signed(r_s0.vec_z);
        n_pa[2] = r_pcos * $signed(r_s0.vec_z);
        n_pa[3] = r_psin * $signed(r_s0.vec_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_sq1[i] <= {1'b0, w_q2[i]};
                r_pa1[i] <= n_pa[i];
            end
            r_s1 <= r_s0;
        end
    end

    // Norm sum and the vector entering the rotation.
    logic [N2W-1:0]        w_n2;
    logic signed [PAW:0]   w_sa, w_sb;
    logic signed [RVW-1:0] w_a0, w_a2;
    logic signed [RVW-1:0] w_vx, w_vy, w_vz;
    logic signed [RVW-1:0] w_rv [3];
    t_sqrt_st              n_sq0;

    assign w_n2 = r_sq1[0] + r_sq1[1] + r_sq1[2] + r_sq1[3];
    assign w_sa = r_pa1[0] + r_pa1[1];
    assign w_sb = r_pa1[2] - r_pa1[3];
    assign w_a0 = rnd_pin(w_sa);
    assign w_a2 = rnd_pin(w_sb);
    assign w_vx = RVW'(r_s1.vec_x);
    assign w_vy = RVW'(r_s1.vec_y);
    assign w_vz = RVW'(r_s1.vec_z);

    always_comb begin
        if (r_s1.req_type) begin
            w_rv[0] = -w_vy;
            w_rv[1] = -w_a2;
            w_rv[2] = w_a0;
        end else begin
            w_rv[0] = w_vx;
            w_rv[1] = w_vy;
            w_rv[2] = w_vz;
        end
        n_sq0.c.req  = r_s1.req_type;
        n_sq0.c.zero = (w_n2 == '0);
        n_sq0.c.q[0] = r_s1.quat_w;
        n_sq0.c.q[1] = r_s1.quat_x;
        n_sq0.c.q[2] = r_s1.quat_y;
        n_sq0.c.q[3] = r_s1.quat_z;
        for (int i = 0; i < 3; i++) begin
            n_sq0.c.rv[i] = w_rv[i];
        end
        n_sq0.n   = {w_n2, {SQSH{1'b0}}};
        n_sq0.res = '0;
    end

    // Square root, one result bit per stage.
    t_sqrt_st       r_sqs  [SQSTEPS+1];
    logic           r_sq_v [SQSTEPS+1];
    t_sqrt_st       n_sqs  [SQSTEPS];
    logic [SQW-1:0] w_sqbit [SQSTEPS];
    logic [SQW-1:0] w_sqsum [SQSTEPS];

    always_comb begin
        for (int i = 0; i < SQSTEPS; i++) begin
            w_sqbit[i] = SQW'(1) << (SQW - 1 - 2 * i);
            w_sqsum[i] = r_sqs[i].res + w_sqbit[i];
            n_sqs[i]   = r_sqs[i];
            if (r_sqs[i].n >= w_sqsum[i]) begin
                n_sqs[i].n   = r_sqs[i].n - w_sqsum[i];
                n_sqs[i].res = (r_sqs[i].res >> 1) + w_sqbit[i];
            end else begin
                n_sqs[i].res = r_sqs[i].res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SQSTEPS; i++) begin
                r_sq_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_sq_v[0] <= r_v1;
            for (int i = 0; i < SQSTEPS; i++) begin
                r_sq_v[i+1] <= r_sq_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqs[0] <= n_sq0;
            for (int i = 0; i < SQSTEPS; i++) begin
                r_sqs[i+1] <= n_sqs[i];
            end
        end
    end

    // Divider setup: numerators of the four unit components.
    logic [SW-1:0]        w_s;
    logic signed [QW-1:0] w_qd  [4];
    logic [QW-1:0]        w_mag [4];
    t_div_st              n_dv0;

    always_comb begin
        w_s         = r_sqs[SQSTEPS].res[SW-1:0];
        n_dv0.req   = r_sqs[SQSTEPS].c.req;
        n_dv0.zero  = r_sqs[SQSTEPS].c.zero;
        n_dv0.rv    = r_sqs[SQSTEPS].c.rv;
        n_dv0.s     = w_s;
        n_dv0.quo   = '0;
        for (int i = 0; i < 4; i++) begin
            w_qd[i]       = $signed(r_sqs[SQSTEPS].c.q[i]);
            n_dv0.neg[i]  = w_qd[i][QW-1];
            w_mag[i]      = w_qd[i][QW-1] ? QW'(-w_qd[i]) : QW'(w_qd[i]);
            n_dv0.rem[i]  = (NUMW'(w_mag[i]) << NUMSH) + NUMW'(w_s >> 1);
        end
    end

    // Restoring division, one quotient bit per stage.
    t_div_st         r_dvs  [QUOW+1];
    logic            r_dv_v [QUOW+1];
    t_div_st         n_dvs  [QUOW];
    logic [NUMW-1:0] w_dd   [QUOW];

    always_comb begin
        for (int j = 0; j < QUOW; j++) begin
            w_dd[j]  = NUMW'(r_dvs[j].s) << (QUOW - 1 - j);
            n_dvs[j] = r_dvs[j];
            for (int c = 0; c < 4; c++) begin
                if (r_dvs[j].rem[c] >= w_dd[j]) begin
                    n_dvs[j].rem[c]             = r_dvs[j].rem[c] - w_dd[j];
                    n_dvs[j].quo[c][QUOW-1-j]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QUOW; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_v[0] <= r_sq_v[SQSTEPS];
            for (int j = 0; j < QUOW; j++) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dvs[0] <= n_dv0;
            for (int j = 0; j < QUOW; j++) begin
                r_dvs[j+1] <= n_dvs[j];
            end
        end
    end

    // Signed unit quaternion, conjugated for map-to-body, identity for a zero input.
    logic signed [UW-1:0]  w_um [4];
    logic                  w_un [4];
    logic signed [UW-1:0]  n_u  [4];
    logic signed [UW-1:0]  r_u  [4];
    logic signed [RVW-1:0] r_urv [3];
    logic                  r_ureq, r_uid, r_uv;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_um[i] = $signed({1'b0, r_dvs[QUOW].quo[i]});
            w_un[i] = r_dvs[QUOW].neg[i] ^ ((i != 0) && !r_dvs[QUOW].req);
            if (r_dvs[QUOW].zero) begin
                n_u[i] = (i == 0) ? $signed(UW'(1) << UF) : '0;
            end else begin
                n_u[i] = w_un[i] ? -w_um[i] : w_um[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
        end else if (w_en) begin
            r_uv <= r_dv_v[QUOW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_u[i] <= n_u[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_urv[i] <= $signed(r_dvs[QUOW].rv[i]);
            end
            r_ureq <= r_dvs[QUOW].req;
            r_uid  <= r_dvs[QUOW].zero;
        end
    end

    // First cross product terms.
    logic signed [PRW-1:0] n_cp [3][2];
    logic signed [PRW-1:0] r_cp [3][2];
    logic signed [UW-1:0]  r_u1 [4];
    logic signed [RVW-1:0] r_rv1 [3];
    logic                  r_req1, r_id1, r_vr1;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_cp[c][0] = r_u[1 + (c + 1) % 3] * r_urv[(c + 2) % 3];
            n_cp[c][1] = r_u[1 + (c + 2) % 3] * r_urv[(c + 1) % 3];
        end
    end

    // Doubled cross product rounded to Q16.16.
    logic signed [CRW-1:0] w_cr [3];
    logic signed [TW-1:0]  r_t [3];
    logic signed [UW-1:0]  r_u2 [4];
    logic signed [RVW-1:0] r_rv2 [3];
    logic                  r_req2, r_id2, r_vr2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_cr[c] = r_cp[c][0] - r_cp[c][1];
        end
    end

    // Second cross product and scalar term, split into high and low partial products.
    logic signed [THW-1:0] w_th [3];
    logic signed [TLW:0]   w_tl [3];
    logic signed [PHW-1:0] n_cph [3][2];
    logic signed [PLW-1:0] n_cpl [3][2];
    logic signed [PHW-1:0] n_wph [3];
    logic signed [PLW-1:0] n_wpl [3];
    logic signed [PHW-1:0] r_cph [3][2];
    logic signed [PLW-1:0] r_cpl [3][2];
    logic signed [PHW-1:0] r_wph [3];
    logic signed [PLW-1:0] r_wpl [3];
    logic signed [RVW-1:0] r_rv3 [3];
    logic                  r_req3, r_id3, r_vr3;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_th[c] = r_t[c][TW-1:TLW];
            w_tl[c] = $signed({1'b0, r_t[c][TLW-1:0]});
        end
        for (int c = 0; c < 3; c++) begin
            n_cph[c][0] = r_u2[1 + (c + 1) % 3] * w_th[(c + 2) % 3];
            n_cpl[c][0] = r_u2[1 + (c + 1) % 3] * w_tl[(c + 2) % 3];
            n_cph[c][1] = r_u2[1 + (c + 2) % 3] * w_th[(c + 1) % 3];
            n_cpl[c][1] = r_u2[1 + (c + 2) % 3] * w_tl[(c + 1) % 3];
            n_wph[c]    = r_u2[0] * w_th[c];
            n_wpl[c]    = r_u2[0] * w_tl[c];
        end
    end

    // Partial product recombination.
    logic signed [ACW-1:0] n_ct [3];
    logic signed [ACW-1:0] n_wt [3];
    logic signed [ACW-1:0] r_ct [3];
    logic signed [ACW-1:0] r_wt [3];
    logic signed [RVW-1:0] r_rv4 [3];
    logic                  r_req4, r_id4, r_vr4;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ct[c] = ((r_cph[c][0] - r_cph[c][1]) <<< TLW) + (r_cpl[c][0] - r_cpl[c][1]);
            n_wt[c] = (r_wph[c] <<< TLW) + r_wpl[c];
        end
    end

    // Rotation accumulator and its rounding.
    logic signed [ACW-1:0] n_acc [3];
    logic signed [ACW-1:0] r_acc [3];
    logic                  r_req5, r_id5, r_vr5;
    logic signed [OW-1:0]  r_o [3];
    logic                  r_req6, r_id6, r_vr6;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = (r_rv4[c] <<< UF) + r_wt[c] + r_ct[c];
        end
    end

    // Axis permutation and mount pitch removal for map-to-body.
    logic signed [PBW-1:0] w_b0, w_b2;
    logic signed [POW-1:0] r_cb0, r_sb2, r_sb0, r_cb2;
    logic signed [OW-1:0]  r_o7 [3];
    logic                  r_req7, r_id7, r_vr7;

    assign w_b0 = PBW'(r_o[2]);
    assign w_b2 = -PBW'(r_o[1]);

    logic signed [FW-1:0] n_f [3];
    logic signed [FW-1:0] r_f [3];
    logic                 r_id8, r_vr8;

    always_comb begin
        if (r_req7) begin
            for (int c = 0; c < 3; c++) begin
                n_f[c] = FW'(r_o7[c]);
            end
        end else begin
            n_f[0] = rnd_pout(r_cb0 - r_sb2);
            n_f[1] = -FW'(r_o7[0]);
            n_f[2] = rnd_pout(r_sb0 + r_cb2);
        end
    end

    // Saturation to the output range.
    logic              w_sat [3];
    logic [VW-1:0]     w_res [3];
    t_out_item         n_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sat[c] = !((&r_f[c][FW-1:VW-1]) || !(|r_f[c][FW-1:VW-1]));
            if (w_sat[c]) begin
                w_res[c] = r_f[c][FW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            end else begin
                w_res[c] = r_f[c][VW-1:0];
            end
        end
        n_out.out_x         = w_res[0];
        n_out.out_y         = w_res[1];
        n_out.out_z         = w_res[2];
        n_out.saturated     = w_sat[0] || w_sat[1] || w_sat[2];
        n_out.identity_used = r_id8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr1   <= 1'b0;
            r_vr2   <= 1'b0;
            r_vr3   <= 1'b0;
            r_vr4   <= 1'b0;
            r_vr5   <= 1'b0;
            r_vr6   <= 1'b0;
            r_vr7   <= 1'b0;
            r_vr8   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_vr1   <= r_uv;
            r_vr2   <= r_vr1;
            r_vr3   <= r_vr2;
            r_vr4   <= r_vr3;
            r_vr5   <= r_vr4;
            r_vr6   <= r_vr5;
            r_vr7   <= r_vr6;
            r_vr8   <= r_vr7;
            r_out_v <= r_vr8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_cp[c][0] <= n_cp[c][0];
                r_cp[c][1] <= n_cp[c][1];
                r_rv1[c]   <= r_urv[c];
                r_t[c]     <= rnd_t(w_cr[c]);
                r_rv2[c]   <= r_rv1[c];
                r_cph[c][0] <= n_cph[c][0];
                r_cph[c][1] <= n_cph[c][1];
                r_cpl[c][0] <= n_cpl[c][0];
                r_cpl[c][1] <= n_cpl[c][1];
                r_wph[c]   <= n_wph[c];
                r_wpl[c]   <= n_wpl[c];
                r_rv3[c]   <= r_rv2[c];
                r_ct[c]    <= n_ct[c];
                r_wt[c]    <= n_wt[c];
                r_rv4[c]   <= r_rv3[c];
                r_acc[c]   <= n_acc[c];
                r_o[c]     <= rnd_acc(r_acc[c]);
                r_o7[c]    <= r_o[c];
                r_f[c]     <= n_f[c];
            end
            for (int i = 0; i < 4; i++) begin
                r_u1[i] <= r_u[i];
                r_u2[i] <= r_u1[i];
            end
            r_cb0  <= r_pcos * w_b0;
            r_sb2  <= r_psin * w_b2;
            r_sb0  <= r_psin * w_b0;
            r_cb2  <= r_pcos * w_b2;
            r_req1 <= r_ureq;
            r_id1  <= r_uid;
            r_req2 <= r_req1;
            r_id2  <= r_id1;
            r_req3 <= r_req2;
            r_id3  <= r_id2;
            r_req4 <= r_req3;
            r_id4  <= r_id3;
            r_req5 <= r_req4;
            r_id5  <= r_id4;
            r_req6 <= r_req5;
            r_id6  <= r_id5;
            r_req7 <= r_req6;
            r_id7  <= r_id6;
            r_id8  <= r_id7;
            r_out  <= n_out;
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_frame_transform_unit: drives random and directed
// transactions through the stream interfaces of qft_if, programs the mount pitch over APB and
// checks each result against a bit-exact fixed-point predictor. Depends on qft_pkg and qft_if.
module tb;
    import qft_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RND_PER_PHASE = 195;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    qft_in_if in_if();
    qft_out_if out_if();

    quaternion_frame_transform_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .o_out(out_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_vectors[$];
    longint    pitch_c = 16384;
    longint    pitch_s = 0;
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_checked = 0;
    int        n_sat = 0;
    int        n_ident = 0;
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        cycle = 0;
    logic      in_took = 1'b0;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    function automatic longint round_shift(longint v, int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (v >= 0) begin
            return (v + half) >>> k;
        end
        return -((-v + half) >>> k);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void rotate_by_unit(input longint u[4], input longint v[3],
                                           output longint o[3]);
        longint c[3];
        longint t[3];
        longint ct[3];
        c[0] = u[2] * v[2] - u[3] * v[1];
        c[1] = u[3] * v[0] - u[1] * v[2];
        c[2] = u[1] * v[1] - u[2] * v[0];
        for (int i = 0; i < 3; i++) t[i] = round_shift(c[i], UF - 1);
        ct[0] = u[2] * t[2] - u[3] * t[1];
        ct[1] = u[3] * t[0] - u[1] * t[2];
        ct[2] = u[1] * t[1] - u[2] * t[0];
        for (int i = 0; i < 3; i++) begin
            o[i] = round_shift(v[i] * (longint'(1) << UF) + u[0] * t[i] + ct[i], UF);
        end
    endfunction

    function automatic t_out_item predict_transform(t_in_item it);
        longint q[4];
        longint u[4];
        longint v[3];
        longint a[3];
        longint b[3];
        longint r[3];
        longint unsigned n2;
        longint unsigned s;
        longint unsigned mag;
        longint unsigned quo;
        t_out_item res;
        q[0] = it.quat_w;
        q[1] = it.quat_x;
        q[2] = it.quat_y;
        q[3] = it.quat_z;
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        res = '0;
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += longint'(q[i] * q[i]);
        if (n2 == 0) begin
            res.identity_used = 1'b1;
            u[0] = longint'(1) << UF;
            u[1] = 0;
            u[2] = 0;
            u[3] = 0;
        end else begin
            s = int_sqrt(n2 << 30);
            for (int i = 0; i < 4; i++) begin
                mag = (q[i] < 0) ? -q[i] : q[i];
                quo = ((mag << 39) + (s >> 1)) / s;
                u[i] = (q[i] < 0) ? -longint'(quo) : longint'(quo);
            end
        end
        if (it.req_type == 1'b0) begin
            for (int i = 1; i < 4; i++) u[i] = -u[i];
            rotate_by_unit(u, v, a);
            b[0] = a[2];
            b[1] = -a[0];
            b[2] = -a[1];
            r[0] = round_shift(pitch_c * b[0] - pitch_s * b[2], PFR);
            r[1] = b[1];
            r[2] = round_shift(pitch_s * b[0] + pitch_c * b[2], PFR);
        end else begin
            a[0] = round_shift(pitch_c * v[0] + pitch_s * v[2], PFR);
            a[1] = v[1];
            a[2] = round_shift(pitch_c * v[2] - pitch_s * v[0], PFR);
            b[0] = -a[1];
            b[1] = -a[2];
            b[2] = a[0];
            rotate_by_unit(u, b, r);
        end
        for (int i = 0; i < 3; i++) begin
            if (r[i] > 64'sd2147483647) begin
                r[i] = 64'sd2147483647;
                res.saturated = 1'b1;
            end else if (r[i] < -64'sd2147483648) begin
                r[i] = -64'sd2147483648;
                res.saturated = 1'b1;
            end
        end
        res.out_x = r[0][31:0];
        res.out_y = r[1][31:0];
        res.out_z = r[2][31:0];
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch at cycle %0d, transaction %0d: %s got %0d expected %0d",
                 cycle, n_checked, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle);
            $display("tb failed");
            $finish;
        end
        in_took <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready) begin
            expected_vectors.push_back(predict_transform(in_if.data));
            n_accepted <= n_accepted + 1;
        end
        if (out_if.valid && out_if.ready) begin
            if (expected_vectors.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = expected_vectors.pop_front();
                if (out_if.data.out_x !== want.out_x) report("out_x", out_if.data.out_x, want.out_x);
                if (out_if.data.out_y !== want.out_y) report("out_y", out_if.data.out_y, want.out_y);
                if (out_if.data.out_z !== want.out_z) report("out_z", out_if.data.out_z, want.out_z);
                if (out_if.data.saturated !== want.saturated) begin
                    report("saturated", out_if.data.saturated, want.saturated);
                end
                if (out_if.data.identity_used !== want.identity_used) begin
                    report("identity_used", out_if.data.identity_used, want.identity_used);
                end
                n_sat <= n_sat + want.saturated;
                n_ident <= n_ident + want.identity_used;
            end
            n_checked <= n_checked + 1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_if.valid || in_took) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data <= pending_items.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic add_item(logic req, int w, int x, int y, int z, int vx, int vy, int vz);
        t_in_item it;
        it.req_type = req;
        it.quat_w = w[15:0];
        it.quat_x = x[15:0];
        it.quat_y = y[15:0];
        it.quat_z = z[15:0];
        it.vec_x = vx;
        it.vec_y = vy;
        it.vec_z = vz;
        pending_items.push_back(it);
        n_queued++;
    endtask

    function automatic int random_quat_comp(int sh);
        int v;
        v = $urandom;
        return v >>> sh;
    endfunction

    function automatic int random_vec_comp();
        int v;
        int sel;
        v = $urandom;
        sel = $urandom_range(9);
        if (sel < 6) begin
            return v >>> $urandom_range(31, 8);
        end else if (sel < 8) begin
            return v;
        end
        return v[0] ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    task automatic add_random_items(int count);
        int sh;
        for (int k = 0; k < count; k++) begin
            sh = $urandom_range(31, 16);
            if ($urandom_range(19) == 0) begin
                add_item($urandom_range(1), 0, 0, 0, 0, random_vec_comp(), random_vec_comp(),
                         random_vec_comp());
            end else begin
                add_item($urandom_range(1), random_quat_comp(sh), random_quat_comp(sh),
                         random_quat_comp(sh), random_quat_comp(sh), random_vec_comp(),
                         random_vec_comp(), random_vec_comp());
            end
        end
    endtask

    task automatic apb_write(t_reg_idx idx, logic signed [CW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << REG_SH;
        pwdata <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PITCH_COS) begin
            pitch_c = value;
        end else begin
            pitch_s = value;
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_vectors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pitch(int c, int s);
        wait_drained();
        apb_write(REG_PITCH_COS, c[15:0]);
        apb_write(REG_PITCH_SIN, s[15:0]);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_item(1'b0, 0, 0, 0, 0, 65536, -65536, 12345);
        add_item(1'b1, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_item(1'b0, 8192, 0, 0, 0, 65536, 131072, 196608);
        add_item(1'b1, 8192, 0, 0, 0, 65536, 131072, 196608);
        add_item(1'b0, -32768, -32768, -32768, -32768, 32'sh80000000, 32'sh80000000,
                 32'sh80000000);
        add_item(1'b1, 32767, 32767, 32767, 32767, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff);
        add_item(1'b0, 0, 32767, 0, 0, 32'sh7fffffff, 0, 32'sh80000000);
        add_item(1'b1, 0, 0, -32768, 0, 32'sh80000000, 32'sh7fffffff, 0);
        add_item(1'b0, 0, 0, 0, 1, 1, -1, 1);
        add_item(1'b1, 1, 0, 0, 0, -1, 1, -1);
        add_item(1'b0, 5793, 5793, 0, 0, 32'sh40000000, 32'sh40000000, 32'sh40000000);
        add_item(1'b1, 4096, 4096, 4096, 4096, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_item(1'b0, -1, 1, -1, 1, 0, 0, 0);
        add_item(1'b1, 32767, -32768, 1, -1, 32'sh5a5a5a5a, 32'sha5a5a5a5, 32'sh12345678);
        set_pitch(-16384, 16384);
        add_item(1'b0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_item(1'b1, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_item(1'b0, 8192, 0, 0, 0, 32'sh7fffffff, 1, 32'sh80000000);
        add_item(1'b1, 5793, 0, 5793, 0, 32'sh80000000, 1, 32'sh7fffffff);
        set_pitch(16384, -16384);
        add_item(1'b0, 8192, 0, 0, 0, 65536, 65536, 65536);
        add_item(1'b1, 8192, 0, 0, 0, 65536, 65536, 65536);

        set_pitch(16384, 0);
        idle_pct = 0;
        stall_pct = 0;
        add_random_items(RND_PER_PHASE);

        set_pitch(15137, -6270);
        idle_pct = 72;
        stall_pct = 0;
        add_random_items(RND_PER_PHASE);

        set_pitch(-11585, 11585);
        idle_pct = 0;
        stall_pct = 72;
        add_random_items(RND_PER_PHASE);

        set_pitch($urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
        idle_pct = 12;
        stall_pct = 12;
        add_random_items(RND_PER_PHASE);

        wait_drained();
        $display("checked %0d transactions over several pitch settings and four idle patterns",
                 n_checked);
        $display("%0d saturated results, %0d zero quaternions, %0d mismatches",
                 n_sat, n_ident, errors);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/qft_pkg.sv
rtl/qft_if.sv
rtl/quaternion_frame_transform_unit.sv
verif/tb.sv
